[rtl/ols_pkg.sv]
package ols_pkg;

    // fixed field widths
    localparam int KEY_W       = 16;
    localparam int IN_ADDR_W   = 24;
    localparam int CONTRIB_W   = 17;
    localparam int POS_W       = 7;
    localparam int MODE_W      = 2;
    localparam int MAXD_W      = 16;
    localparam int INV_W       = 24;
    localparam int STEP_W      = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int EXP_TERMS   = 12;

    localparam int MAX_LINE_LENGTH_DEF = 64;
    localparam int ADDRESS_BITS_DEF    = 24;

    localparam logic [POS_W-1:0]     POS_LIMIT = 7'd127;
    localparam logic [CONTRIB_W-1:0] ONE_Q16   = 17'h10000;

    localparam logic [MODE_W-1:0] MODE_SQRT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXP  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RST = 2'd1;
    localparam logic [MAXD_W-1:0] MAXD_RST = 16'd2560;
    localparam logic [INV_W-1:0]  INV_RST  = 24'd6554;
    localparam logic [STEP_W-1:0] STEP_RST = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FUNCTION_MODE = 2'd0,
        CFG_MAX_DISTANCE  = 2'd1,
        CFG_INV_MAX_DIST  = 2'd2,
        CFG_STEP_LENGTH   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MAXD_W-1:0] max_dist;
        logic [INV_W-1:0]  inv_max;
        logic [STEP_W-1:0] step_len;
    } cfg_t;

    typedef struct packed {
        logic                 done;
        logic [CONTRIB_W-1:0] value;
    } ols_rsp_t;

    typedef enum logic [3:0] {
        T_IDLE, T_RD, T_CMP, T_PUSH, T_WAIT, T_EMIT, T_FRD, T_FCMP, T_FIN
    } top_state_t;

    typedef enum logic [3:0] {
        C_IDLE, C_DIST, C_RATIO, C_SEL, C_SQRT, C_EMUL, C_EDIV, C_EFIN, C_DONE
    } con_state_t;

endpackage

[rtl/obscurance_line_sweep.sv]
// Obscurance line sweep.
// Input stream (s_): one voxel per transfer; tdata = key [15:0],
// voxel_address [39:16]; tuser = faces_away; tlast = line_end.
// Result stream (m_): tdata = target_address [23:0], contribution [40:24];
// tlast marks the final result caused by an input voxel. A voxel may cause
// no result, or up to MAX_LINE_LENGTH results.
// Config: cfg_we writes cfg_wdata into register cfg_addr (0 function mode,
// 1 max distance, 2 inverse max distance, 3 step length); write only when idle.
// One voxel is processed at a time. Unless the stack is full, its top is
// read and compared until a compare stops the pops or it is empty, and the
// voxel is then pushed. Each facing pop adds the contribution run (square
// root, or an exponential series of 12 terms of one multiply and a divide)
// and the emit. A line end then reads out every entry, emitting facing ones.
// The stack sits in a one-port-read memory, so each pop is a read and a compare.
// Results are held one deep so tlast can be set; a voxel whose results are
// done may be taken while its last result still waits in the output register.
// A stalled m_tready simply holds the sweep at the next emit or finish.
// Reset (synchronous, aresetn low) empties the stack, clears the step
// position and restores register defaults; stack contents are not cleared.
module obscurance_line_sweep import ols_pkg::*; #(
    parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEF,
    parameter int ADDRESS_BITS    = ADDRESS_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key, voxel_address
    input  logic                   s_tuser,   // faces_away
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // target_address, contribution, zero pad
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AB    = ADDRESS_BITS;
    localparam int CNT_W = $clog2(MAX_LINE_LENGTH + 1);
    localparam int IDX_W = $clog2(MAX_LINE_LENGTH);
    localparam int ENT_W = KEY_W + AB + 1 + POS_W;

    cfg_t cfg_reg;

    top_state_t state_reg, state_next;

    logic [KEY_W-1:0]     cur_key_reg;
    logic [AB-1:0]        cur_addr_reg;
    logic                 cur_away_reg, cur_last_reg, cur_full_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [AB-1:0]        pend_addr_reg;
    logic [CONTRIB_W-1:0] pend_val_reg;
    logic                 ret_flush_reg;
    logic                 hold_valid_reg;
    logic [AB-1:0]        hold_addr_reg;
    logic [CONTRIB_W-1:0] hold_val_reg;
    logic                 m_valid_reg, m_last_reg;
    logic [AB-1:0]        m_addr_reg;
    logic [CONTRIB_W-1:0] m_val_reg;

    logic                 mem_we, mem_re;
    logic [ENT_W-1:0]     mem_wdata, mem_rdata;
    logic [CNT_W-1:0]     count_m1;
    logic [KEY_W-1:0]     rd_key;
    logic [AB-1:0]        rd_addr;
    logic                 rd_away;
    logic [POS_W-1:0]     rd_pos;
    logic                 key_le;
    logic                 out_free, emit_ok, emit_fire, fin_fire;
    logic                 con_start;
    ols_rsp_t             con_rsp;
    logic [31:0]          in_addr_ext, out_addr_ext;

    assign in_addr_ext  = 32'(s_tdata[IN_TDATA_W-1:KEY_W]);
    assign out_addr_ext = 32'(m_addr_reg);

    assign count_m1 = count_reg - CNT_W'(1);
    assign rd_key   = mem_rdata[ENT_W-1 -: KEY_W];
    assign rd_addr  = mem_rdata[POS_W+1 +: AB];
    assign rd_away  = mem_rdata[POS_W];
    assign rd_pos   = mem_rdata[POS_W-1:0];
    assign key_le   = rd_key <= cur_key_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit_ok   = !hold_valid_reg || out_free;
    assign emit_fire = (state_reg == T_EMIT) && emit_ok;
    assign fin_fire  = (state_reg == T_FIN) && hold_valid_reg && out_free;

    assign mem_wdata = {cur_key_reg, cur_addr_reg, cur_away_reg, pos_reg};

    ols_stack #(
        .DEPTH (MAX_LINE_LENGTH),
        .WIDTH (ENT_W)
    ) u_stack (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (count_m1[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    ols_contrib u_contrib (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .start   (con_start),
        .steps   (pos_reg - rd_pos),
        .rsp     (con_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode     <= MODE_RST;
            cfg_reg.max_dist <= MAXD_RST;
            cfg_reg.inv_max  <= INV_RST;
            cfg_reg.step_len <= STEP_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_FUNCTION_MODE: cfg_reg.mode     <= cfg_wdata[MODE_W-1:0];
                CFG_MAX_DISTANCE:  cfg_reg.max_dist <= cfg_wdata[MAXD_W-1:0];
                CFG_INV_MAX_DIST:  cfg_reg.inv_max  <= cfg_wdata[INV_W-1:0];
                CFG_STEP_LENGTH:   cfg_reg.step_len <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        con_start  = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            T_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = T_RD;
            end
            T_RD: begin
                if (!cur_full_reg && count_reg != '0) begin
                    mem_re     = 1'b1;
                    state_next = T_CMP;
                end else begin
                    state_next = T_PUSH;
                end
            end
            T_CMP: begin
                if (key_le) begin
                    if (rd_away) begin
                        con_start  = 1'b1;
                        state_next = T_WAIT;
                    end else begin
                        state_next = T_RD;
                    end
                end else begin
                    state_next = T_PUSH;
                end
            end
            T_PUSH: begin
                mem_we     = !cur_full_reg;
                state_next = cur_last_reg ? T_FRD : T_FIN;
            end
            T_WAIT: if (con_rsp.done) state_next = T_EMIT;
            T_EMIT: if (emit_ok) state_next = ret_flush_reg ? T_FRD : T_RD;
            T_FRD: begin
                if (count_reg != '0) begin
                    mem_re     = 1'b1;
                    state_next = T_FCMP;
                end else begin
                    state_next = T_FIN;
                end
            end
            T_FCMP:  state_next = rd_away ? T_EMIT : T_FRD;
            T_FIN:   if (!hold_valid_reg || out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pos_reg        <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                T_CMP:  if (key_le) count_reg <= count_m1;
                T_FCMP: count_reg <= count_m1;
                T_PUSH: if (!cur_full_reg) count_reg <= count_reg + CNT_W'(1);
                T_FIN: begin
                    if (!hold_valid_reg || out_free) begin
                        if (cur_last_reg) begin
                            pos_reg <= '0;
                        end else if (pos_reg < POS_LIMIT) begin
                            pos_reg <= pos_reg + POS_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
            if (emit_fire) begin
                hold_valid_reg <= 1'b1;
                if (hold_valid_reg) m_valid_reg <= 1'b1;
            end
            if (fin_fire) begin
                hold_valid_reg <= 1'b0;
                m_valid_reg    <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (state_reg == T_IDLE && s_tvalid) begin
            cur_key_reg  <= s_tdata[KEY_W-1:0];
            cur_addr_reg <= in_addr_ext[AB-1:0];
            cur_away_reg <= s_tuser;
            cur_last_reg <= s_tlast;
            cur_full_reg <= count_reg == CNT_W'(MAX_LINE_LENGTH);
        end
        if (state_reg == T_CMP) begin
            pend_addr_reg <= rd_addr;
            ret_flush_reg <= 1'b0;
        end
        if (state_reg == T_FCMP) begin
            pend_addr_reg <= rd_addr;
            pend_val_reg  <= ONE_Q16;
            ret_flush_reg <= 1'b1;
        end
        if (state_reg == T_WAIT && con_rsp.done) begin
            pend_val_reg <= con_rsp.value;
        end
        if (emit_fire) begin
            hold_addr_reg <= pend_addr_reg;
            hold_val_reg  <= pend_val_reg;
            if (hold_valid_reg) begin
                m_addr_reg <= hold_addr_reg;
                m_val_reg  <= hold_val_reg;
                m_last_reg <= 1'b0;
            end
        end
        if (fin_fire) begin
            m_addr_reg <= hold_addr_reg;
            m_val_reg  <= hold_val_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_TDATA_W'({m_val_reg, out_addr_ext[IN_ADDR_W-1:0]});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_LINE_LENGTH))
        else $error("stack count beyond depth");

    a_contrib_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_val_reg <= ONE_Q16)
        else $error("contribution above one");

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == T_IDLE |-> !hold_valid_reg)
        else $error("held result left behind at idle");

    a_con_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        con_rsp.done |-> state_reg == T_WAIT)
        else $error("contribution finished outside wait");
`endif

endmodule

[rtl/ols_stack.sv]
module ols_stack import ols_pkg::*; #(
    parameter int DEPTH = MAX_LINE_LENGTH_DEF,
    parameter int WIDTH = KEY_W + ADDRESS_BITS_DEF + 1 + POS_W
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ols_contrib.sv]
module ols_contrib import ols_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             start,
    input  logic [POS_W-1:0] steps,
    output ols_rsp_t         rsp
);

    localparam int DIST_W = POS_W + STEP_W;
    localparam int PROD_W = DIST_W + INV_W;
    localparam int RAT_W  = 25;
    localparam int SQ_W   = 35;
    localparam int TERM_W = 33;
    localparam int Q_W    = 40;
    localparam int SUM_W  = 37;
    localparam int DIV_PER_CYC = 8;
    localparam int DIV_CYC     = Q_W / DIV_PER_CYC;

    con_state_t state_reg, state_next;

    logic [POS_W-1:0]        steps_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [RAT_W-1:0]        ratio_reg;
    logic [SQ_W-1:0]         v_reg, res_reg, bit_reg;
    logic [TERM_W-1:0]       term_reg;
    logic [Q_W-1:0]          quot_reg;
    logic [3:0]              rem_reg;
    logic [3:0]              k_reg;
    logic [2:0]              dcnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CONTRIB_W-1:0]    val_reg;

    logic                    beyond;
    logic [PROD_W-7:0]       ratio_wide;
    logic [RAT_W-1:0]        ratio_c;
    logic [SQ_W-1:0]         sq_try;
    logic                    sq_take;
    logic [TERM_W+RAT_W-1:0] mprod;
    logic [Q_W-1:0]          q_nx;
    logic [3:0]              r_nx;
    logic [4:0]              r_try;
    logic signed [SUM_W-1:0] rest;
    logic [SUM_W-1:0]        rounded;
    logic [CONTRIB_W-1:0]    exp_val;

    assign beyond     = dist_reg > {cfg.max_dist, 6'b0};
    assign ratio_wide = prod_reg[PROD_W-1:6];
    assign ratio_c    = (ratio_wide > (PROD_W-5)'(1 << 24)) ? RAT_W'(1 << 24)
                                                            : ratio_wide[RAT_W-1:0];
    assign sq_try     = res_reg + bit_reg;
    assign sq_take    = v_reg >= sq_try;
    assign mprod      = term_reg * ratio_reg;

    // restoring division by the small term index, eight quotient bits a cycle
    always_comb begin
        q_nx  = quot_reg;
        r_nx  = rem_reg;
        r_try = '0;
        for (int i = 0; i < DIV_PER_CYC; i++) begin
            r_try = {r_nx, q_nx[Q_W-1]};
            q_nx  = {q_nx[Q_W-2:0], 1'b0};
            if (r_try >= {1'b0, k_reg}) begin
                r_nx    = 4'(r_try - {1'b0, k_reg});
                q_nx[0] = 1'b1;
            end else begin
                r_nx = r_try[3:0];
            end
        end
    end

    always_comb begin
        rest    = SUM_W'(64'sh1_0000_0000) - sum_reg;
        rounded = '0;
        exp_val = '0;
        if (rest >= 0) begin
            rounded = SUM_W'(rest) + SUM_W'(32768);
            if (rounded[SUM_W-1:16] > (SUM_W-16)'(ONE_Q16)) begin
                exp_val = ONE_Q16;
            end else begin
                exp_val = rounded[16+CONTRIB_W-1:16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  if (start) state_next = C_DIST;
            C_DIST:  state_next = C_RATIO;
            C_RATIO: state_next = beyond ? C_DONE : C_SEL;
            C_SEL: begin
                if (cfg.mode == MODE_SQRT) begin
                    state_next = C_SQRT;
                end else if (cfg.mode == MODE_EXP) begin
                    state_next = C_EMUL;
                end else begin
                    state_next = C_DONE;
                end
            end
            C_SQRT:  if (bit_reg == SQ_W'(1)) state_next = C_DONE;
            C_EMUL:  state_next = C_EDIV;
            C_EDIV: begin
                if (dcnt_reg == 3'(DIV_CYC - 1)) begin
                    state_next = (k_reg == 4'(EXP_TERMS)) ? C_EFIN : C_EMUL;
                end
            end
            C_EFIN:  state_next = C_DONE;
            C_DONE:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            C_IDLE: begin
                steps_reg <= steps;
            end
            C_DIST: begin
                dist_reg <= steps_reg * cfg.step_len;
            end
            C_RATIO: begin
                prod_reg <= dist_reg * cfg.inv_max;
                val_reg  <= ONE_Q16;
            end
            C_SEL: begin
                ratio_reg <= ratio_c;
                v_reg     <= SQ_W'({ratio_c, 8'b0});
                res_reg   <= '0;
                bit_reg   <= SQ_W'(64'h1_0000_0000);
                term_reg  <= TERM_W'(64'h1_0000_0000);
                sum_reg   <= SUM_W'(64'sh1_0000_0000);
                k_reg     <= 4'd1;
                val_reg   <= '0;
            end
            C_SQRT: begin
                if (sq_take) begin
                    v_reg   <= v_reg - sq_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                // last iteration result lands in res_reg; latch on the way out
                if (bit_reg == SQ_W'(1)) begin
                    val_reg <= sq_take ? CONTRIB_W'((res_reg >> 1) + bit_reg)
                                       : CONTRIB_W'(res_reg >> 1);
                end
            end
            C_EMUL: begin
                quot_reg <= Q_W'(mprod >> 24);
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            C_EDIV: begin
                quot_reg <= q_nx;
                rem_reg  <= r_nx;
                dcnt_reg <= dcnt_reg + 3'd1;
                if (dcnt_reg == 3'(DIV_CYC - 1)) begin
                    term_reg <= q_nx[TERM_W-1:0];
                    if (k_reg[0]) begin
                        sum_reg <= sum_reg - SUM_W'(q_nx[TERM_W-1:0]);
                    end else begin
                        sum_reg <= sum_reg + SUM_W'(q_nx[TERM_W-1:0]);
                    end
                    k_reg <= k_reg + 4'd1;
                end
            end
            C_EFIN: begin
                val_reg <= exp_val;
            end
            default: begin
            end
        endcase
    end

    assign rsp.done  = (state_reg == C_DONE);
    assign rsp.value = val_reg;

endmodule

[tb/ols_sweep_checker.sv]
module ols_sweep_checker import ols_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key, voxel_address
    input  logic                   s_tuser,   // faces_away
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // target_address, contribution, zero pad
    input  logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     failures,
    output int                     outstanding
);

    localparam int DEPTH = MAX_LINE_LENGTH_DEF;

    typedef struct {
        logic [IN_ADDR_W-1:0] addr;
        logic [CONTRIB_W-1:0] amount;
        logic                 last;
    } hit_t;

    hit_t hits_due[$];

    logic [MODE_W-1:0] mode_r;
    logic [MAXD_W-1:0] maxd_r;
    logic [INV_W-1:0]  inv_r;
    logic [STEP_W-1:0] step_r;

    logic [KEY_W-1:0]     stk_key  [DEPTH];
    logic [IN_ADDR_W-1:0] stk_addr [DEPTH];
    logic                 stk_away [DEPTH];
    int                   stk_pos  [DEPTH];
    int depth_now;
    int sweep_pos;
    int fails;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 1 - exp(-ratio) by a truncated alternating series
    function automatic logic [CONTRIB_W-1:0] fade(longint unsigned ratio);
        longint unsigned term;
        longint          acc;
        longint          rest;
        longint unsigned c;
        term = 64'd1 << 32;
        acc  = longint'(term);
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * ratio) >> 24) / k;
            if (k % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
        end
        rest = (longint'(1) << 32) - acc;
        if (rest < 0) rest = 0;
        c = (longint'(rest) + 32768) >> 16;
        if (c > ONE_Q16) c = ONE_Q16;
        return c[CONTRIB_W-1:0];
    endfunction

    function automatic logic [CONTRIB_W-1:0] amount_at(int steps);
        longint unsigned span;
        longint unsigned ratio;
        longint unsigned s;
        span = longint'(steps) * step_r;
        if (span > (longint'(maxd_r) << 6)) return ONE_Q16;
        ratio = (span * inv_r) >> 6;
        if (ratio > (64'd1 << 24)) ratio = 64'd1 << 24;
        if (mode_r == MODE_SQRT) begin
            s = isqrt(ratio << 8);
            return s[CONTRIB_W-1:0];
        end
        if (mode_r == MODE_EXP) return fade(ratio);
        return '0;
    endfunction

    function automatic void push_hit(logic [IN_ADDR_W-1:0] a, logic [CONTRIB_W-1:0] v);
        hit_t h;
        h.addr   = a;
        h.amount = v;
        h.last   = 1'b0;
        hits_due.push_back(h);
    endfunction

    task automatic sweep_voxel(logic [KEY_W-1:0] key, logic [IN_ADDR_W-1:0] addr,
                               logic away, logic line_end);
        int n0;
        n0 = hits_due.size();
        if (depth_now < DEPTH) begin
            while (depth_now > 0 && stk_key[depth_now-1] <= key) begin
                depth_now--;
                if (stk_away[depth_now])
                    push_hit(stk_addr[depth_now], amount_at(sweep_pos - stk_pos[depth_now]));
            end
            stk_key[depth_now]  = key;
            stk_addr[depth_now] = addr;
            stk_away[depth_now] = away;
            stk_pos[depth_now]  = sweep_pos;
            depth_now++;
        end
        if (line_end) begin
            while (depth_now > 0) begin
                depth_now--;
                if (stk_away[depth_now]) push_hit(stk_addr[depth_now], ONE_Q16);
            end
            sweep_pos = 0;
        end else if (sweep_pos < POS_LIMIT) begin
            sweep_pos++;
        end
        if (hits_due.size() > n0) hits_due[hits_due.size()-1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        hit_t h;
        if (!aresetn) begin
            mode_r    = MODE_RST;
            maxd_r    = MAXD_RST;
            inv_r     = INV_RST;
            step_r    = STEP_RST;
            depth_now = 0;
            sweep_pos = 0;
            fails     = 0;
            hits_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_FUNCTION_MODE: mode_r = cfg_wdata[MODE_W-1:0];
                    CFG_MAX_DISTANCE:  maxd_r = cfg_wdata[MAXD_W-1:0];
                    CFG_INV_MAX_DIST:  inv_r  = cfg_wdata[INV_W-1:0];
                    CFG_STEP_LENGTH:   step_r = cfg_wdata[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
                sweep_voxel(s_tdata[15:0], s_tdata[39:16], s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (hits_due.size() == 0) begin
                    $display("%0t unexpected transfer: expected none, got addr %h amount %h last %b",
                             $time, m_tdata[23:0], m_tdata[40:24], m_tlast);
                    fails++;
                end else begin
                    h = hits_due.pop_front();
                    if (m_tdata[23:0] !== h.addr || m_tdata[40:24] !== h.amount ||
                        m_tlast !== h.last) begin
                        $display("%0t mismatch: expected addr %h amount %h last %b, got %h %h %b",
                                 $time, h.addr, h.amount, h.last,
                                 m_tdata[23:0], m_tdata[40:24], m_tlast);
                        fails++;
                    end
                end
            end
        end
        failures    <= fails;
        outstanding <= hits_due.size();
    end

endmodule

[tb/tb_obscurance_line_sweep.sv]
module tb_obscurance_line_sweep;
    import ols_pkg::*;

    localparam int LIMIT = 2000000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // key, voxel_address
    logic                   s_tuser;   // faces_away
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // target_address, contribution, zero pad
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    int failures;
    int outstanding;
    int cycles;
    bit quiet;
    bit stall_req;

    obscurance_line_sweep uut (.*);

    ols_sweep_checker chk (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_obscurance_line_sweep NOT OK");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        bit held;
        held = 0;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (stall_req && !held) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send(logic [KEY_W-1:0] key, logic [IN_ADDR_W-1:0] addr,
                        logic away, logic line_end);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, key};
        s_tuser  <= away;
        s_tlast  <= line_end;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (400) @(posedge aclk);
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_all(int mode, int maxd, int inv, int stp);
        set_reg(CFG_FUNCTION_MODE, CFG_DATA_W'(mode));
        set_reg(CFG_MAX_DISTANCE, CFG_DATA_W'(maxd));
        set_reg(CFG_INV_MAX_DIST, CFG_DATA_W'(inv));
        set_reg(CFG_STEP_LENGTH, CFG_DATA_W'(stp));
    endtask

    // key drawn from a narrow band now and then so equal keys turn up
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 2) == 0) return KEY_W'($urandom_range(0, 3));
        return KEY_W'($urandom);
    endfunction

    task automatic random_items(int n);
        int len;
        while (n > 0) begin
            if ($urandom_range(0, 5) == 0) begin
                send(pick_key(), IN_ADDR_W'($urandom), 1'($urandom), 1'($urandom));
                n--;
            end else begin
                len = $urandom_range(1, (n < 12) ? n : 12);
                for (int i = 0; i < len; i++)
                    send(pick_key(), IN_ADDR_W'($urandom), 1'($urandom), i == len - 1);
                n -= len;
            end
        end
    endtask

    initial begin
        cycles    = 0;
        quiet     = 0;
        stall_req = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_FUNCTION_MODE;
        cfg_wdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // long hold-off while the first voxels pile up results
        stall_req = 1;

        // directed: field extremes under the reset registers
        send(16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        send(16'h0000, 24'h000000, 1'b1, 1'b0);
        send(16'h0000, 24'h123456, 1'b0, 1'b0);
        send(16'h8000, 24'hABCDEF, 1'b1, 1'b0);
        send(16'hFFFF, 24'h000001, 1'b1, 1'b1);
        send(16'h0001, 24'hFFFFFE, 1'b1, 1'b1);
        // full stack: falling keys, the last two are dropped, line end flushes
        for (int i = 0; i < 66; i++)
            send(KEY_W'(1000 - i), IN_ADDR_W'(i), 1'(i % 2), i == 65);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_all(0, 0, 0, 0);
                1: set_all(2, 65535, 24'hFFFFFF, 15'h7FFF);
                2: set_all(2, 2560, 6554, 16384);
                3: set_all(3, 1, 1, 28378);
                4: set_all(1, 65535, 256, 16384);
                default: set_all(1, $urandom_range(1, 4000), $urandom, $urandom);
            endcase
            if (ph == 5) quiet = 1;
            if (ph == 1) begin
                send(16'h0010, 24'h000A0A, 1'b1, 1'b0);
                send(16'h0010, 24'h000B0B, 1'b1, 1'b0);
                send(16'hFFFF, 24'h000C0C, 1'b1, 1'b1);
            end
            random_items(6);
            settle();
        end

        if (failures == 0) begin
            $display("tb_obscurance_line_sweep OK");
        end else begin
            $display("tb_obscurance_line_sweep NOT OK");
        end
        $finish;
    end

endmodule
